// ===== hw/rtl/aoe_pkg.sv =====
package aoe_pkg;

  localparam int MAX_ACT = 64;
  localparam int MAX_EV  = 64;
  localparam int DUR_W   = 16;
  localparam int NUM_W   = 7;
  localparam int EV_W    = 6;
  localparam int TIME_W  = 22;
  localparam int DEG_W   = 7;
  localparam int CNT_W   = 7;
  localparam int ADDR_W  = 6;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [DEG_W-1:0]  DEG_MAX  = '1;

  typedef struct packed {
    logic [EV_W-1:0]  src;
    logic [EV_W-1:0]  dst;
    logic [DUR_W-1:0] dur;
  } edge_t;

  typedef struct packed {
    logic [DEG_W-1:0]  deg;
    logic [TIME_W-1:0] early;
    logic [TIME_W-1:0] late;
  } evt_t;

  localparam int EDGE_W = $bits(edge_t);
  localparam int EVT_W  = $bits(evt_t);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_DEG,
    OP_PUSH0,
    OP_POP,
    OP_POP_W,
    OP_TOP_W,
    OP_FWD_CHK,
    OP_FWD_UPD,
    OP_HI_RD,
    OP_HI_WR,
    OP_BK_NEXT,
    OP_BK_U,
    OP_BK_CHK,
    OP_BK_UPD,
    OP_U_RD,
    OP_U_WR,
    OP_OUT_E,
    OP_OUT_S,
    OP_OUT_D,
    OP_OUT_ADV,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic good;
    logic last;
    logic cnt_zero;
    logic sp_zero;
    logic k_end;
    logic i_zero;
    logic match_top;
    logic match_u;
    logic u_hi;
    logic out_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/aoe_ram.sv =====
module aoe_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/aoe_ctrl.sv =====
module aoe_ctrl import aoe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_LD_CHK  = 25'h0000002,
    S_LD_DEG  = 25'h0000004,
    S_START   = 25'h0000008,
    S_POP     = 25'h0000010,
    S_POP_W   = 25'h0000020,
    S_TOP_W   = 25'h0000040,
    S_E_RD    = 25'h0000080,
    S_E_CHK   = 25'h0000100,
    S_E_UPD   = 25'h0000200,
    S_HI_RD   = 25'h0000400,
    S_HI_WR   = 25'h0000800,
    S_BK_NEXT = 25'h0001000,
    S_BK_U    = 25'h0002000,
    S_B_RD    = 25'h0004000,
    S_B_CHK   = 25'h0008000,
    S_B_UPD   = 25'h0010000,
    S_U_RD    = 25'h0020000,
    S_U_WR    = 25'h0040000,
    S_O_RD    = 25'h0080000,
    S_O_E     = 25'h0100000,
    S_O_S     = 25'h0200000,
    S_O_D     = 25'h0400000,
    S_O_V     = 25'h0800000,
    S_CLR     = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_O_V);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_LD_CHK;
        end
      end
      S_LD_CHK: begin
        if (sts.good) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_LD_DEG;
        end else begin
          state_nxt = sts.last ? S_START : S_IDLE;
        end
      end
      S_LD_DEG: begin
        cmd.op    = OP_DEG;
        state_nxt = sts.last ? S_START : S_IDLE;
      end
      S_START: begin
        if (sts.cnt_zero) begin
          state_nxt = S_CLR;
        end else begin
          cmd.op    = OP_PUSH0;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sts.sp_zero) begin
          state_nxt = S_HI_RD;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        cmd.op    = OP_POP_W;
        state_nxt = S_TOP_W;
      end
      S_TOP_W: begin
        cmd.op    = OP_TOP_W;
        state_nxt = S_E_RD;
      end
      S_E_RD: begin
        state_nxt = sts.k_end ? S_POP : S_E_CHK;
      end
      S_E_CHK: begin
        cmd.op    = OP_FWD_CHK;
        state_nxt = sts.match_top ? S_E_UPD : S_E_RD;
      end
      S_E_UPD: begin
        cmd.op    = OP_FWD_UPD;
        state_nxt = S_E_RD;
      end
      S_HI_RD: begin
        cmd.op    = OP_HI_RD;
        state_nxt = S_HI_WR;
      end
      S_HI_WR: begin
        cmd.op    = OP_HI_WR;
        state_nxt = S_BK_NEXT;
      end
      S_BK_NEXT: begin
        cmd.op    = OP_BK_NEXT;
        state_nxt = sts.i_zero ? S_O_RD : S_BK_U;
      end
      S_BK_U: begin
        cmd.op    = OP_BK_U;
        state_nxt = sts.u_hi ? S_BK_NEXT : S_B_RD;
      end
      S_B_RD: begin
        state_nxt = sts.k_end ? S_U_RD : S_B_CHK;
      end
      S_B_CHK: begin
        cmd.op    = OP_BK_CHK;
        state_nxt = sts.match_u ? S_B_UPD : S_B_RD;
      end
      S_B_UPD: begin
        cmd.op    = OP_BK_UPD;
        state_nxt = S_B_RD;
      end
      S_U_RD: begin
        cmd.op    = OP_U_RD;
        state_nxt = S_U_WR;
      end
      S_U_WR: begin
        cmd.op    = OP_U_WR;
        state_nxt = S_BK_NEXT;
      end
      S_O_RD: begin
        state_nxt = S_O_E;
      end
      S_O_E: begin
        cmd.op    = OP_OUT_E;
        state_nxt = S_O_S;
      end
      S_O_S: begin
        cmd.op    = OP_OUT_S;
        state_nxt = S_O_D;
      end
      S_O_D: begin
        cmd.op    = OP_OUT_D;
        state_nxt = S_O_V;
      end
      S_O_V: begin
        if (!out_stall) begin
          cmd.op    = OP_OUT_ADV;
          state_nxt = sts.out_last ? S_CLR : S_O_RD;
        end
      end
      S_CLR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/aoe_dp.sv =====
module aoe_dp import aoe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NUM_W-1:0]  in_activity_number,
  input  logic [EV_W-1:0]   in_source_event,
  input  logic [EV_W-1:0]   in_dest_event,
  input  logic [DUR_W-1:0]  in_duration,
  input  logic              in_last_record,
  output logic [NUM_W-1:0]  out_activity,
  output logic [TIME_W-1:0] out_early_start,
  output logic [TIME_W-1:0] out_late_start,
  output logic [TIME_W-1:0] out_slack,
  output logic              out_critical,
  output logic              out_last_result,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts
);

  edge_t             edge_rd, edge_wd;
  logic              edge_we;
  logic [ADDR_W-1:0] edge_wa;

  evt_t              evt_q, evt_rd, evt_wd;
  logic              evt_we;
  logic [ADDR_W-1:0] evt_wa, evt_ra;

  logic              stk_we;
  logic [ADDR_W-1:0] stk_wa, stk_ra;
  logic [EV_W-1:0]   stk_wd, stk_rd;

  logic              topo_we;
  logic [ADDR_W-1:0] topo_ra;
  logic [EV_W-1:0]   topo_rd;

  logic [NUM_W-1:0]  num_r;
  logic [EV_W-1:0]   src_in_r, dst_in_r;
  logic [DUR_W-1:0]  dur_in_r;
  logic              last_r;
  logic [CNT_W-1:0]  cnt_r, sp_r, n_r, i_r, k_r;
  logic [EV_W-1:0]   hi_r, top_r, u_r;
  logic [TIME_W-1:0] early_top_r, best_r, es_r;
  edge_t             e_r;
  logic [MAX_EV-1:0] evt_vld_r, pushed_r;
  logic              evt_vq_r;

  logic [NUM_W-1:0]  slot;
  logic [CNT_W-1:0]  sp_dec, i_dec;
  logic [TIME_W:0]   f_sum;
  logic [TIME_W-1:0] f_t, f_early, b_t;
  logic [DEG_W-1:0]  f_deg;
  logic              f_push;

  assign slot   = num_r - NUM_W'(1);
  assign sp_dec = sp_r - CNT_W'(1);
  assign i_dec  = i_r - CNT_W'(1);

  assign evt_rd.deg   = evt_vq_r ? evt_q.deg   : '0;
  assign evt_rd.early = evt_vq_r ? evt_q.early : '0;
  assign evt_rd.late  = evt_vq_r ? evt_q.late  : TIME_MAX;

  assign f_sum   = {1'b0, early_top_r} + (TIME_W + 1)'(e_r.dur);
  assign f_t     = f_sum[TIME_W] ? TIME_MAX : f_sum[TIME_W-1:0];
  assign f_early = (f_t > evt_rd.early) ? f_t : evt_rd.early;
  assign f_deg   = (evt_rd.deg <= DEG_W'(1)) ? '0 : evt_rd.deg - DEG_W'(1);
  assign f_push  = (evt_rd.deg <= DEG_W'(1)) && !pushed_r[e_r.dst] &&
                   (sp_r < CNT_W'(MAX_EV));
  assign b_t     = (evt_rd.late > TIME_W'(e_r.dur)) ?
                   evt_rd.late - TIME_W'(e_r.dur) : '0;

  assign edge_wa = slot[ADDR_W-1:0];
  assign edge_wd = '{src: src_in_r, dst: dst_in_r, dur: dur_in_r};
  assign edge_we = (cmd.op == OP_LOAD);

  assign stk_ra  = sp_dec[ADDR_W-1:0];
  assign topo_we = (cmd.op == OP_POP_W);
  assign topo_ra = i_dec[ADDR_W-1:0];

  always_comb begin
    evt_we = 1'b0;
    evt_wa = dst_in_r;
    evt_wd = evt_rd;
    evt_ra = dst_in_r;
    stk_we = 1'b0;
    stk_wa = sp_r[ADDR_W-1:0];
    stk_wd = e_r.dst;
    case (cmd.op)
      OP_DEG: begin
        evt_we = 1'b1;
        if (evt_rd.deg != DEG_MAX) begin
          evt_wd.deg = evt_rd.deg + DEG_W'(1);
        end
      end
      OP_PUSH0: begin
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = '0;
      end
      OP_POP_W: evt_ra = stk_rd;
      OP_FWD_CHK, OP_BK_CHK: evt_ra = edge_rd.dst;
      OP_FWD_UPD: begin
        evt_we       = 1'b1;
        evt_wa       = e_r.dst;
        evt_wd.deg   = f_deg;
        evt_wd.early = f_early;
        stk_we       = f_push;
      end
      OP_HI_RD: evt_ra = hi_r;
      OP_HI_WR: begin
        evt_we      = 1'b1;
        evt_wa      = hi_r;
        evt_wd.late = evt_rd.early;
      end
      OP_U_RD: evt_ra = u_r;
      OP_U_WR: begin
        evt_we      = 1'b1;
        evt_wa      = u_r;
        evt_wd.late = best_r;
      end
      OP_OUT_E: evt_ra = edge_rd.src;
      OP_OUT_S: evt_ra = e_r.dst;
      default: ;
    endcase
  end

  aoe_ram #(.W(EDGE_W), .D(MAX_ACT)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
    .raddr(k_r[ADDR_W-1:0]), .rdata(edge_rd)
  );

  aoe_ram #(.W(EVT_W), .D(MAX_EV)) u_evt_ram (
    .clk(clk), .we(evt_we), .waddr(evt_wa), .wdata(evt_wd),
    .raddr(evt_ra), .rdata(evt_q)
  );

  aoe_ram #(.W(EV_W), .D(MAX_EV)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(stk_ra), .rdata(stk_rd)
  );

  aoe_ram #(.W(EV_W), .D(MAX_EV)) u_topo_ram (
    .clk(clk), .we(topo_we), .waddr(n_r[ADDR_W-1:0]), .wdata(stk_rd),
    .raddr(topo_ra), .rdata(topo_rd)
  );

  always_ff @(posedge clk) begin
    evt_vq_r <= evt_vld_r[evt_ra];
    if (!rst_n) begin
      cnt_r     <= '0;
      hi_r      <= '0;
      evt_vld_r <= '0;
      pushed_r  <= '0;
      sp_r      <= '0;
    end else begin
      if (evt_we) begin
        evt_vld_r[evt_wa] <= 1'b1;
      end
      case (cmd.op)
        OP_LATCH: begin
          num_r    <= in_activity_number;
          src_in_r <= in_source_event;
          dst_in_r <= in_dest_event;
          dur_in_r <= in_duration;
          last_r   <= in_last_record;
        end
        OP_LOAD: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (dst_in_r > hi_r) begin
            hi_r <= dst_in_r;
          end
        end
        OP_PUSH0: begin
          pushed_r[0] <= 1'b1;
          sp_r        <= CNT_W'(1);
          n_r         <= '0;
        end
        OP_POP: sp_r <= sp_dec;
        OP_POP_W: begin
          top_r <= stk_rd;
          n_r   <= n_r + CNT_W'(1);
        end
        OP_TOP_W: begin
          early_top_r <= evt_rd.early;
          k_r         <= '0;
        end
        OP_FWD_CHK: begin
          e_r <= edge_rd;
          if (edge_rd.src != top_r) begin
            k_r <= k_r + CNT_W'(1);
          end
        end
        OP_FWD_UPD: begin
          if (f_push) begin
            pushed_r[e_r.dst] <= 1'b1;
            sp_r              <= sp_r + CNT_W'(1);
          end
          if (e_r.dst == top_r) begin
            early_top_r <= f_early;
          end
          k_r <= k_r + CNT_W'(1);
        end
        OP_HI_WR: i_r <= n_r;
        OP_BK_NEXT: begin
          if (i_r == '0) begin
            k_r <= '0;
          end else begin
            i_r <= i_dec;
          end
        end
        OP_BK_U: begin
          u_r    <= topo_rd;
          best_r <= TIME_MAX;
          k_r    <= '0;
        end
        OP_BK_CHK: begin
          e_r <= edge_rd;
          if (edge_rd.src != u_r) begin
            k_r <= k_r + CNT_W'(1);
          end
        end
        OP_BK_UPD: begin
          if (b_t < best_r) begin
            best_r <= b_t;
          end
          k_r <= k_r + CNT_W'(1);
        end
        OP_OUT_E: e_r <= edge_rd;
        OP_OUT_S: es_r <= evt_rd.early;
        OP_OUT_D: begin
          out_activity    <= k_r + CNT_W'(1);
          out_early_start <= es_r;
          out_late_start  <= b_t;
          out_slack       <= (b_t > es_r) ? b_t - es_r : '0;
          out_critical    <= (b_t <= es_r);
          out_last_result <= (k_r + CNT_W'(1) == cnt_r);
        end
        OP_OUT_ADV: k_r <= k_r + CNT_W'(1);
        OP_CLEAR: begin
          cnt_r     <= '0;
          hi_r      <= '0;
          evt_vld_r <= '0;
          pushed_r  <= '0;
          sp_r      <= '0;
        end
        default: ;
      endcase
    end
  end

  assign sts.good      = (num_r != '0) && (num_r <= NUM_W'(MAX_ACT)) &&
                         (cnt_r < CNT_W'(MAX_ACT));
  assign sts.last      = last_r;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.sp_zero   = (sp_r == '0);
  assign sts.k_end     = (k_r == cnt_r);
  assign sts.i_zero    = (i_r == '0);
  assign sts.match_top = (edge_rd.src == top_r);
  assign sts.match_u   = (edge_rd.src == u_r);
  assign sts.u_hi      = (topo_rd == hi_r);
  assign sts.out_last  = (k_r + CNT_W'(1) == cnt_r);

endmodule

// ===== hw/rtl/aoe_critical_path_core.sv =====
// Critical path analysis of an activity-on-edge network. Activity records are
// taken one at a time; the record flagged last starts the job. The forward
// pass pops each reachable event from a stack and scans the whole edge table
// for the activities leaving that event; the backward pass scans the table
// again for each event in reverse topological order, except the
// highest-numbered destination event. Results follow in activity order, the
// next one computed only after the output takes the current one; no new
// record is taken until the job's last result is delivered.
module aoe_critical_path_core import aoe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [NUM_W-1:0]  in_activity_number,
  input  logic [EV_W-1:0]   in_source_event,
  input  logic [EV_W-1:0]   in_dest_event,
  input  logic [DUR_W-1:0]  in_duration,
  input  logic              in_last_record,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NUM_W-1:0]  out_activity,
  output logic [TIME_W-1:0] out_early_start,
  output logic [TIME_W-1:0] out_late_start,
  output logic [TIME_W-1:0] out_slack,
  output logic              out_critical,
  output logic              out_last_result
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  aoe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  aoe_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_activity_number(in_activity_number), .in_source_event(in_source_event),
    .in_dest_event(in_dest_event), .in_duration(in_duration),
    .in_last_record(in_last_record),
    .out_activity(out_activity), .out_early_start(out_early_start),
    .out_late_start(out_late_start), .out_slack(out_slack),
    .out_critical(out_critical), .out_last_result(out_last_result),
    .cmd(cmd), .sts(sts)
  );

`ifndef SYNTHESIS
  a_no_accept_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_critical_slack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_critical == (out_slack == '0)))
    else $error("critical flag disagrees with slack");

  a_job_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_result |=> !out_valid && cmd.op == OP_CLEAR)
    else $error("job did not end after final result");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import aoe_pkg::*;

  localparam int TIME_LIM = 4194303;
  localparam int WDOG_LIM = 200000;
  localparam int HOLD_LEN = 20000;

  typedef struct {
    int unsigned num;
    int unsigned src;
    int unsigned dst;
    int unsigned dur;
    bit          last;
  } rec_t;

  typedef struct {
    rec_t        r;
    bit          typed;
    int unsigned es;
    int unsigned ls;
    int unsigned slk;
    bit          crit;
  } row_t;

  typedef struct {
    logic [NUM_W-1:0]  act;
    logic [TIME_W-1:0] es;
    logic [TIME_W-1:0] ls;
    logic [TIME_W-1:0] slk;
    logic              crit;
    logic              lastr;
  } timing_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [NUM_W-1:0]  in_activity_number;
  logic [EV_W-1:0]   in_source_event;
  logic [EV_W-1:0]   in_dest_event;
  logic [DUR_W-1:0]  in_duration;
  logic              in_last_record;
  logic              out_valid;
  logic              out_stall;
  logic [NUM_W-1:0]  out_activity;
  logic [TIME_W-1:0] out_early_start;
  logic [TIME_W-1:0] out_late_start;
  logic [TIME_W-1:0] out_slack;
  logic              out_critical;
  logic              out_last_result;

  aoe_critical_path_core u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // network model
  int unsigned m_src[MAX_ACT];
  int unsigned m_dst[MAX_ACT];
  int unsigned m_dur[MAX_ACT];
  int unsigned m_deg[MAX_EV];
  int unsigned m_early[MAX_EV];
  int unsigned m_late[MAX_EV];
  int unsigned m_order[MAX_EV];
  int unsigned m_stk[MAX_EV];
  int unsigned m_cnt;
  int unsigned m_hi;

  rec_t    stim_q[$];
  bit      typed_q[$];
  timing_t typed_res[$];
  timing_t timing_q[$];

  int      n_items;
  int      n_sent;
  int      errors;
  int      snd_idle;
  int      rcv_idle;
  bit      running;
  bit      pressure;
  bit      held;
  int      hold_cnt;
  int      quiet;

  row_t dir_tbl[17] = '{
    '{'{0, 0, 0, 0, 1}, 0, 0, 0, 0, 0},
    '{'{1, 0, 5, 65535, 1}, 1, 0, 0, 0, 1},
    '{'{1, 0, 0, 0, 1}, 1, 0, 0, 0, 1},
    '{'{1, 3, 4, 9, 1}, 1, 0, 0, 0, 1},
    '{'{1, 0, 1, 3, 0}, 0, 0, 0, 0, 0},
    '{'{2, 1, 2, 4, 0}, 0, 0, 0, 0, 0},
    '{'{3, 2, 1, 5, 0}, 0, 0, 0, 0, 0},
    '{'{4, 10, 11, 7, 0}, 0, 0, 0, 0, 0},
    '{'{5, 0, 63, 0, 0}, 0, 0, 0, 0, 0},
    '{'{0, 63, 63, 65535, 0}, 0, 0, 0, 0, 0},
    '{'{127, 63, 0, 65535, 0}, 0, 0, 0, 0, 0},
    '{'{6, 0, 2, 100, 0}, 0, 0, 0, 0, 0},
    '{'{7, 63, 62, 1, 1}, 0, 0, 0, 0, 0},
    '{'{1, 0, 1, 10, 0}, 0, 0, 0, 0, 0},
    '{'{2, 0, 2, 3, 0}, 0, 0, 0, 0, 0},
    '{'{3, 1, 3, 5, 0}, 0, 0, 0, 0, 0},
    '{'{100, 2, 3, 1, 1}, 0, 0, 0, 0, 0}
  };

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > TIME_LIM) ? TIME_LIM : int'(s);
  endfunction

  function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic void clear_net();
    for (int i = 0; i < MAX_EV; i++) begin
      m_deg[i] = 0;
      m_early[i] = 0;
      m_late[i] = TIME_LIM;
    end
    for (int i = 0; i < MAX_ACT; i++) begin
      m_src[i] = 0;
      m_dst[i] = 0;
      m_dur[i] = 0;
    end
    m_cnt = 0;
    m_hi = 0;
  endfunction

  function automatic void solve_net(bit keep);
    bit          pushed[MAX_EV];
    int unsigned sp, n, top, d, t, u, best, es, ls;
    timing_t     res;
    sp = 0;
    n = 0;
    for (int i = 0; i < MAX_EV; i++) pushed[i] = 0;
    m_stk[sp++] = 0;
    pushed[0] = 1;
    while (sp > 0) begin
      top = m_stk[--sp];
      m_order[n++] = top;
      for (int k = 0; k < m_cnt; k++) begin
        if (m_src[k] == top) begin
          d = m_dst[k];
          if (m_deg[d] <= 1) begin
            m_deg[d] = 0;
            if (!pushed[d] && sp < MAX_EV) begin
              pushed[d] = 1;
              m_stk[sp++] = d;
            end
          end else begin
            m_deg[d] -= 1;
          end
          t = sat_add(m_early[top], m_dur[k]);
          if (t > m_early[d]) m_early[d] = t;
        end
      end
    end
    m_late[m_hi] = m_early[m_hi];
    for (int i = n; i > 0; i--) begin
      u = m_order[i-1];
      best = TIME_LIM;
      if (u != m_hi) begin
        for (int k = 0; k < m_cnt; k++) begin
          if (m_src[k] == u) begin
            t = floor_sub(m_late[m_dst[k]], m_dur[k]);
            if (t < best) best = t;
          end
        end
        m_late[u] = best;
      end
    end
    for (int k = 0; k < m_cnt; k++) begin
      es = m_early[m_src[k]];
      ls = floor_sub(m_late[m_dst[k]], m_dur[k]);
      res.act = k + 1;
      res.es = es;
      res.ls = ls;
      res.slk = floor_sub(ls, es);
      res.crit = (ls <= es);
      res.lastr = (k + 1 == m_cnt);
      if (keep) timing_q.insert(timing_q.size(), res);
    end
  endfunction

  function automatic void absorb_record(rec_t r, bit typed);
    if (r.num >= 1 && r.num <= MAX_ACT && m_cnt < MAX_ACT) begin
      m_src[r.num-1] = r.src;
      m_dst[r.num-1] = r.dst;
      m_dur[r.num-1] = r.dur;
      if (m_deg[r.dst] < 127) m_deg[r.dst] += 1;
      if (r.dst > m_hi) m_hi = r.dst;
      m_cnt += 1;
    end
    if (r.last) begin
      if (m_cnt > 0) solve_net(!typed);
      if (typed) timing_q.insert(timing_q.size(), typed_res.pop_front());
      clear_net();
    end
  endfunction

  function automatic int unsigned pick_dur();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(0, 20);
      default: return $urandom & 16'hFFFF;
    endcase
  endfunction

  function automatic void push_noise(bit last);
    rec_t r;
    r.num = ($urandom_range(0, 1)) ? 0 : $urandom_range(65, 127);
    r.src = $urandom_range(0, 63);
    r.dst = $urandom_range(0, 63);
    r.dur = $urandom & 16'hFFFF;
    r.last = last;
    stim_q.insert(stim_q.size(), r);
    typed_q.insert(typed_q.size(), 0);
  endfunction

  function automatic void add_job(int n, bit dag, bit overfill);
    rec_t r;
    int   nev;
    nev = (n + 1 > MAX_EV) ? MAX_EV : n + 1;
    if (nev < 2) nev = 2;
    for (int k = 1; k <= n; k++) begin
      if ($urandom_range(0, 9) == 0) push_noise(0);
      r.num = k;
      if (dag) begin
        r.src = (k == 1) ? 0 : $urandom_range(0, nev - 2);
        r.dst = $urandom_range(r.src + 1, nev - 1);
      end else begin
        r.src = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, nev - 1);
        r.dst = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, nev - 1);
      end
      r.dur = pick_dur();
      r.last = (k == n) && !overfill;
      if (k == n && !overfill && $urandom_range(0, 7) == 0) begin
        r.last = 0;
        stim_q.insert(stim_q.size(), r);
        typed_q.insert(typed_q.size(), 0);
        push_noise(1);
      end else begin
        stim_q.insert(stim_q.size(), r);
        typed_q.insert(typed_q.size(), 0);
      end
    end
    if (overfill) begin
      r.num = $urandom_range(1, MAX_ACT);
      r.src = $urandom_range(0, 63);
      r.dst = $urandom_range(0, 63);
      r.dur = pick_dur();
      r.last = 1;
      stim_q.insert(stim_q.size(), r);
      typed_q.insert(typed_q.size(), 0);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (running) begin
      if (in_valid && !in_stall) begin
        absorb_record(stim_q[n_sent], typed_q[n_sent]);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (n_sent >= n_items || $urandom_range(0, 99) < snd_idle) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_activity_number <= stim_q[n_sent].num;
          in_source_event <= stim_q[n_sent].src;
          in_dest_event <= stim_q[n_sent].dst;
          in_duration <= stim_q[n_sent].dur;
          in_last_record <= stim_q[n_sent].last;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    timing_t e;
    if (pressure && !held) begin
      held <= 1'b1;
      hold_cnt <= HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
    if (running && out_valid && !out_stall) begin
      if (timing_q.size() == 0) begin
        $display("%0t: unexpected result act=%0d", $realtime, out_activity);
        errors++;
      end else begin
        e = timing_q.pop_front();
        if (out_activity !== e.act || out_early_start !== e.es || out_late_start !== e.ls ||
            out_slack !== e.slk || out_critical !== e.crit || out_last_result !== e.lastr) begin
          $display("%0t: mismatch exp act=%0d es=%0d ls=%0d slk=%0d crit=%0b last=%0b",
                   $realtime, e.act, e.es, e.ls, e.slk, e.crit, e.lastr);
          $display("%0t:          got act=%0d es=%0d ls=%0d slk=%0d crit=%0b last=%0b",
                   $realtime, out_activity, out_early_start, out_late_start, out_slack,
                   out_critical, out_last_result);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (running) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG_LIM) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    timing_t t;
    int      dir_n;
    bit      big_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_activity_number = '0;
    in_source_event = '0;
    in_dest_event = '0;
    in_duration = '0;
    in_last_record = 1'b0;
    out_stall = 1'b0;
    running = 0;
    pressure = 0;
    held = 0;
    hold_cnt = 0;
    quiet = 0;
    errors = 0;
    n_sent = 0;
    snd_idle = 8;
    rcv_idle = 65;
    big_done = 0;
    clear_net();

    foreach (dir_tbl[i]) begin
      stim_q.insert(stim_q.size(), dir_tbl[i].r);
      typed_q.insert(typed_q.size(), dir_tbl[i].typed);
      if (dir_tbl[i].typed) begin
        t.act = 1;
        t.es = dir_tbl[i].es;
        t.ls = dir_tbl[i].ls;
        t.slk = dir_tbl[i].slk;
        t.crit = dir_tbl[i].crit;
        t.lastr = 1;
        typed_res.insert(typed_res.size(), t);
      end
    end
    dir_n = stim_q.size();
    add_job(MAX_ACT, 1, 1);
    while (stim_q.size() < 300) begin
      if (!big_done && stim_q.size() >= 200) begin
        add_job(MAX_ACT, 0, 0);
        big_done = 1;
      end else begin
        add_job($urandom_range(1, 8), $urandom_range(0, 3) != 0, 0);
      end
    end
    add_job(MAX_ACT, 1, 0);
    n_items = stim_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    running <= 1;

    while (n_sent < n_items) begin
      @(posedge clk);
      if (n_sent > dir_n + 20) pressure <= 1;
      if (n_sent >= n_items / 3 && n_sent < 2 * n_items / 3) begin
        snd_idle <= 65;
        rcv_idle <= 8;
      end else if (n_sent >= 2 * n_items / 3) begin
        snd_idle <= 0;
        rcv_idle <= 0;
      end
    end
    while (timing_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && timing_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
